>>> rtl/uvsp_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the UV sphere generator.
`timescale 1ns / 1ps
package uvsp_pkg;
	localparam int ATAN_LEN = 24;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_SEGMENTS = 2'd1;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic flip;
	} cordic_t;

	typedef struct packed {
		logic point_valid;
		logic quad_valid;
		logic [15:0] radius;
		logic [15:0] corner_a;
		logic [15:0] corner_c;
	} side_t;

	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		case (i)
			5'd0: atan_turns = 32'd536870912;
			5'd1: atan_turns = 32'd316933406;
			5'd2: atan_turns = 32'd167458907;
			5'd3: atan_turns = 32'd85004756;
			5'd4: atan_turns = 32'd42667331;
			5'd5: atan_turns = 32'd21354465;
			5'd6: atan_turns = 32'd10679838;
			5'd7: atan_turns = 32'd5340245;
			5'd8: atan_turns = 32'd2670163;
			5'd9: atan_turns = 32'd1335087;
			5'd10: atan_turns = 32'd667544;
			5'd11: atan_turns = 32'd333772;
			5'd12: atan_turns = 32'd166886;
			5'd13: atan_turns = 32'd83443;
			5'd14: atan_turns = 32'd41722;
			5'd15: atan_turns = 32'd20861;
			5'd16: atan_turns = 32'd10430;
			5'd17: atan_turns = 32'd5215;
			5'd18: atan_turns = 32'd2608;
			5'd19: atan_turns = 32'd1304;
			5'd20: atan_turns = 32'd652;
			5'd21: atan_turns = 32'd326;
			5'd22: atan_turns = 32'd163;
			5'd23: atan_turns = 32'd81;
			default: atan_turns = 32'd0;
		endcase
	endfunction

	function automatic logic [15:0] color_of(input logic signed [33:0] u);
		logic signed [35:0] t;
		begin
			t = 36'(u) + 36'(Q30_ONE) + 36'sd16384;
			if (t < 0) color_of = 16'd0;
			else if ((t >>> 15) > 36'sd65535) color_of = 16'hFFFF;
			else color_of = t[30:15];
		end
	endfunction
endpackage

>>> rtl/uvsp_cordic_cell.sv
// One CORDIC rotation cell: a micro-rotation on two angle lanes, registered.
`timescale 1ns / 1ps
module uvsp_cordic_cell
	import uvsp_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic clk,
	input  logic en,
	input  cordic_t th_in,
	input  cordic_t ph_in,
	input  side_t side_in,
	output cordic_t th_out,
	output cordic_t ph_out,
	output side_t side_out
);
	function automatic cordic_t rot(input cordic_t c);
		cordic_t r;
		logic signed [33:0] dx, dy, at;
		begin
			r = c;
			dx = c.y >>> SHIFT;
			dy = c.x >>> SHIFT;
			at = $signed({2'b00, atan_turns(5'(SHIFT))});
			if (!c.z[33]) begin
				r.x = c.x - dx; r.y = c.y + dy; r.z = c.z - at;
			end else begin
				r.x = c.x + dx; r.y = c.y - dy; r.z = c.z + at;
			end
			rot = r;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			th_out <= rot(th_in);
			ph_out <= rot(ph_in);
			side_out <= side_in;
		end
	end
endmodule

>>> rtl/uv_sphere_point_generator_unit.sv
// UV sphere point generator: grid point in, position, color and quad corners out.
// Throughput: one point per cycle; the whole pipeline advances together and
// stalls only when the output register is full and not taken.
// A segment_count write reloads the angle reciprocal; input waits meanwhile.
// Reset: arst_n clears valid flags and sets radius to 256, segment_count to 16.
`timescale 1ns / 1ps
module uv_sphere_point_generator_unit
	import uvsp_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // lat_step[7:0], lon_step[15:8]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [167:0] m_axis_tdata  // point_valid, pos_x, pos_y, pos_z, red, green,
	                                    // blue, quad_valid, corner_a..corner_d
);
	localparam int PIPE = CORDIC_STAGES + 5;

	logic [15:0] radius_q;
	logic [7:0] segs_reg_q;
	logic [7:0] segs;
	logic [48:0] recip_q; // floor(2^48/S)+1
	logic seg_wr;

	assign pready = 1'b1;
	assign segs = (segs_reg_q == 8'd0) ? 8'd1 : segs_reg_q;
	assign seg_wr = psel && penable && pwrite && (paddr[2] == REG_SEGMENTS[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			segs_reg_q <= 8'd16;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_RADIUS[0]: radius_q <= pwdata[15:0];
				REG_SEGMENTS[0]: segs_reg_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// reciprocal by restoring division of 2^48, one quotient bit per cycle
	logic div_busy_q;
	logic [5:0] div_cnt_q;
	logic [7:0] div_rem_q;
	logic [48:0] div_quo_q;
	logic [8:0] rem_sh;
	logic rem_ge;
	assign rem_sh = {div_rem_q, div_cnt_q == 6'd49};
	assign rem_ge = rem_sh >= {1'b0, segs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
			div_rem_q <= '0;
			div_quo_q <= '0;
			recip_q <= (49'd1 << 44) + 49'd1;
		end else if (seg_wr) begin
			div_busy_q <= 1'b1;
			div_cnt_q <= 6'd49;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (div_busy_q) begin
			div_rem_q <= rem_ge ? 8'(rem_sh - {1'b0, segs}) : rem_sh[7:0];
			div_quo_q <= {div_quo_q[47:0], rem_ge};
			div_cnt_q <= div_cnt_q - 6'd1;
			if (div_cnt_q == 6'd1) begin
				div_busy_q <= 1'b0;
				recip_q <= {div_quo_q[47:0], rem_ge} + 49'd1;
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_RADIUS[0]: prdata = {16'd0, radius_q};
			default: prdata = {24'd0, segs_reg_q};
		endcase
	end

	logic [PIPE-1:0] vld_q;
	logic out_full_q;
	logic adv;
	assign adv = !out_full_q || m_axis_tready;
	assign s_axis_tready = adv && !div_busy_q;
	assign m_axis_tvalid = out_full_q;

	// stage 1: range checks, corner indices and angle numerators times reciprocal
	logic [7:0] y_in, x_in;
	assign y_in = s_axis_tdata[7:0];
	assign x_in = s_axis_tdata[15:8];
	logic [56:0] thp_s1, php_s1;
	side_t side_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			thp_s1 <= {49'd0, y_in} * {8'd0, recip_q};
			php_s1 <= {49'd0, x_in} * {8'd0, recip_q};
			side_s1.point_valid <= (y_in <= segs) && (x_in <= segs);
			side_s1.quad_valid <= (y_in < segs) && (x_in < segs);
			side_s1.radius <= radius_q;
			side_s1.corner_a <= 16'(y_in) * (16'(segs) + 16'd1) + 16'(x_in);
			side_s1.corner_c <= (16'(y_in) + 16'd1) * (16'(segs) + 16'd1) + 16'(x_in);
		end
	end

	// stage 2: angles and quadrant fold
	function automatic cordic_t fold(input logic [31:0] a0);
		cordic_t c;
		logic [31:0] a, t;
		begin
			t = a0 + 32'h4000_0000;
			c.flip = t[31];
			a = t[31] ? a0 - 32'h8000_0000 : a0;
			c.x = CORDIC_GAIN;
			c.y = '0;
			c.z = $signed({{2{a[31]}}, a});
			fold = c;
		end
	endfunction
	cordic_t th_s2, ph_s2;
	side_t side_s2;
	cordic_t th_c [0:CORDIC_STAGES];
	cordic_t ph_c [0:CORDIC_STAGES];
	side_t side_c [0:CORDIC_STAGES];
	always_ff @(posedge clk) begin
		if (adv) begin
			th_s2 <= fold(thp_s1[48:17]);
			ph_s2 <= fold(php_s1[47:16]);
			side_s2 <= side_s1;
		end
	end
	assign th_c[0] = th_s2;
	assign ph_c[0] = ph_s2;
	assign side_c[0] = side_s2;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		uvsp_cordic_cell #(.SHIFT(i)) u_cell (
			.clk(clk), .en(adv),
			.th_in(th_c[i]), .ph_in(ph_c[i]), .side_in(side_c[i]),
			.th_out(th_c[i+1]), .ph_out(ph_c[i+1]), .side_out(side_c[i+1])
		);
	end

	// unflip, then direction products
	logic signed [33:0] ct, st, cp, sp;
	assign ct = th_c[CORDIC_STAGES].flip ? -th_c[CORDIC_STAGES].x : th_c[CORDIC_STAGES].x;
	assign st = th_c[CORDIC_STAGES].flip ? -th_c[CORDIC_STAGES].y : th_c[CORDIC_STAGES].y;
	assign cp = ph_c[CORDIC_STAGES].flip ? -ph_c[CORDIC_STAGES].x : ph_c[CORDIC_STAGES].x;
	assign sp = ph_c[CORDIC_STAGES].flip ? -ph_c[CORDIC_STAGES].y : ph_c[CORDIC_STAGES].y;

	logic signed [67:0] uxp_s3, uzp_s3;
	logic signed [33:0] uy_s3;
	side_t side_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			uxp_s3 <= 68'(cp) * 68'(st);
			uzp_s3 <= 68'(sp) * 68'(st);
			uy_s3 <= ct;
			side_s3 <= side_c[CORDIC_STAGES];
		end
	end

	logic signed [33:0] ux_s4, uy_s4, uz_s4;
	side_t side_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s4 <= 34'(uxp_s3 >>> 30);
			uz_s4 <= 34'(uzp_s3 >>> 30);
			uy_s4 <= uy_s3;
			side_s4 <= side_s3;
		end
	end

	logic signed [51:0] px_s5, py_s5, pz_s5;
	logic [15:0] r_s5, g_s5, b_s5;
	side_t side_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s5 <= 52'(ux_s4) * $signed({36'd0, side_s4.radius});
			py_s5 <= 52'(uy_s4) * $signed({36'd0, side_s4.radius});
			pz_s5 <= 52'(uz_s4) * $signed({36'd0, side_s4.radius});
			r_s5 <= color_of(ux_s4);
			g_s5 <= color_of(uy_s4);
			b_s5 <= color_of(uz_s4);
			side_s5 <= side_s4;
		end
	end

	function automatic logic [16:0] pos_of(input logic signed [51:0] p);
		logic signed [51:0] q;
		begin
			q = (p + 52'sd536870912) >>> 30;
			if (q > 52'sd65535) pos_of = 17'sd65535;
			else if (q < -52'sd65535) pos_of = -17'sd65535;
			else pos_of = q[16:0];
		end
	endfunction

	logic [167:0] out_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s5.point_valid)
				out_q <= {
					3'd0,
					side_s5.quad_valid ? side_s5.corner_c + 16'd1 : 16'd0,
					side_s5.quad_valid ? side_s5.corner_c : 16'd0,
					side_s5.quad_valid ? side_s5.corner_a + 16'd1 : 16'd0,
					side_s5.quad_valid ? side_s5.corner_a : 16'd0,
					side_s5.quad_valid,
					b_s5, g_s5, r_s5,
					pos_of(pz_s5), pos_of(py_s5), pos_of(px_s5),
					1'b1};
			else
				out_q <= '0;
		end
	end
	assign m_axis_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_full_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE-2:0], s_axis_tvalid && !div_busy_q};
			out_full_q <= vld_q[PIPE-1];
		end
	end
endmodule
